@@ src/afbf_pkg.sv @@
// ----------------------------------------------------------------------------
// afbf_pkg : shared types and constants of the audio frame base64 framer
// Job record passed from the front to the back, queue sizing, character
// tables for the JSON header, the base64 alphabet and the line tail.
// ----------------------------------------------------------------------------
package afbf_pkg;

   localparam int RESET_MAX_FRAME = 1161;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int BCD_DIGITS      = 10;
   localparam int HEAD_OPEN_LEN   = 22;
   localparam int HEAD_CLOSE_LEN  = 8;
   localparam int TAIL_LEN        = 3;

   localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
   localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   // One accepted byte worth of output work
   typedef struct packed {
      logic              drop;     // single drop result
      logic              header;   // first byte of an admitted frame
      logic              last;     // closes the line
      logic [3:0]        ndig;     // decimal digits of the sequence number, 1..10
      logic [39:0]       bcd;      // sequence number in BCD
      logic [2:0]        nchr;     // base64 characters in chr, 1..4
      logic [3:0][7:0]   chr;      // base64 characters incl. padding
      logic [31:0]       sent;     // frames_sent after this byte
      logic [31:0]       dropped;  // frames_dropped after this byte
   } afbf_job_type;

   typedef enum logic [2:0] {
      STEP_DROP,
      STEP_OPEN,
      STEP_DIGIT,
      STEP_CLOSE_HDR,
      STEP_B64,
      STEP_TAIL
   } afbf_step_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26)       r = 8'h41 + {2'b00, v};
      else if (v < 6'd52)  r = 8'h61 + {2'b00, v} - 8'd26;
      else if (v < 6'd62)  r = 8'h30 + {2'b00, v} - 8'd52;
      else if (v == 6'd62) r = 8'h2B;
      else                 r = 8'h2F;
      return r;
   endfunction

   // {"type":"audio","seq":
   function automatic logic [7:0] head_open_char(input logic [4:0] i);
      logic [7:0] r;
      unique case (i)
         5'd0:    r = 8'h7B;
         5'd1:    r = 8'h22;
         5'd2:    r = 8'h74;
         5'd3:    r = 8'h79;
         5'd4:    r = 8'h70;
         5'd5:    r = 8'h65;
         5'd6:    r = 8'h22;
         5'd7:    r = 8'h3A;
         5'd8:    r = 8'h22;
         5'd9:    r = 8'h61;
         5'd10:   r = 8'h75;
         5'd11:   r = 8'h64;
         5'd12:   r = 8'h69;
         5'd13:   r = 8'h6F;
         5'd14:   r = 8'h22;
         5'd15:   r = 8'h2C;
         5'd16:   r = 8'h22;
         5'd17:   r = 8'h73;
         5'd18:   r = 8'h65;
         5'd19:   r = 8'h71;
         5'd20:   r = 8'h22;
         5'd21:   r = 8'h3A;
         default: r = CHAR_NUL;
      endcase
      return r;
   endfunction

   // ,"pcm":"
   function automatic logic [7:0] head_close_char(input logic [2:0] i);
      logic [7:0] r;
      unique case (i)
         3'd0: r = 8'h2C;
         3'd1: r = 8'h22;
         3'd2: r = 8'h70;
         3'd3: r = 8'h63;
         3'd4: r = 8'h6D;
         3'd5: r = 8'h22;
         3'd6: r = 8'h3A;
         3'd7: r = 8'h22;
      endcase
      return r;
   endfunction

   // "}\n
   function automatic logic [7:0] tail_char(input logic [1:0] i);
      logic [7:0] r;
      unique case (i)
         2'd0:    r = 8'h22;
         2'd1:    r = 8'h7D;
         2'd2:    r = 8'h0A;
         default: r = CHAR_NUL;
      endcase
      return r;
   endfunction

endpackage

@@ src/audio_frame_base64_framer.sv @@
// ----------------------------------------------------------------------------
// audio_frame_base64_framer : PCM frame to JSON/base64 text line framer
// Path: with the back end idle, an item taken is held in the queue slot, then
//   the current-job register, then the output register as its first character.
// Throughput: one input byte a cycle while the 4-entry job queue has room;
//   output runs at one character a cycle while rsp_stall is low, 0 to 47
//   characters per byte (none for the swallowed bytes of a dropped frame), so
//   the sustained byte rate is set by the character sequencer in the back end.
// Reset: counters, sequence number and frame state clear; limit becomes 1161.
// ----------------------------------------------------------------------------
module audio_frame_base64_framer #(
   parameter int LENGTH_WIDTH = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   input  logic [LENGTH_WIDTH-1:0] req_frame_length,
   input  logic                    req_link_up,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_char,
   output logic                    rsp_line_end,
   output logic                    rsp_dropped,
   output logic [31:0]             rsp_frames_sent,
   output logic [31:0]             rsp_frames_dropped,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [LENGTH_WIDTH-1:0] csr_data
);
   import afbf_pkg::*;

   // front -> queue and queue -> back job transactions
   afbf_job_type fq_job, qb_job;
   logic         fq_valid, fq_ready;
   logic         qb_valid, qb_take;

   // Front: admit or drop a frame on its first byte, count, split into sextets
   afbf_front #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_frame_length (req_frame_length),
      .req_link_up      (req_link_up),
      .job_valid        (fq_valid),
      .job_ready        (fq_ready),
      .job              (fq_job)
   );

   // Queue: hold jobs so that the front keeps taking bytes during long headers
   afbf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_job   (fq_job),
      .rd_valid (qb_valid),
      .rd_take  (qb_take),
      .rd_job   (qb_job)
   );

   // Back: one character a cycle into the output register unless stalled
   afbf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (qb_valid),
      .job_take           (qb_take),
      .job                (qb_job),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_line_end       (rsp_line_end),
      .rsp_dropped        (rsp_dropped),
      .rsp_frames_sent    (rsp_frames_sent),
      .rsp_frames_dropped (rsp_frames_dropped)
   );

   // A drop result is a bare line end carrying a NUL character
   a_drop_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_line_end && (rsp_out_char == CHAR_NUL))
      else $error("drop result malformed");

   // A line of a sent frame closes only on a newline
   a_line_newline : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end && !rsp_dropped |-> (rsp_out_char == 8'h0A))
      else $error("line end without newline");

   // The front is never held off while the queue has room for a job
   a_front_stall : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !fq_ready)
      else $error("front stalled with queue space");

endmodule

@@ src/afbf_front.sv @@
// ----------------------------------------------------------------------------
// afbf_front : admission and classification
// Holds the frame limit register, checks each frame on its first byte,
// keeps sequence and frame counters and splits bytes into base64 sextets.
// ----------------------------------------------------------------------------
module afbf_front #(
   parameter int LENGTH_WIDTH = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [LENGTH_WIDTH-1:0] csr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   input  logic [LENGTH_WIDTH-1:0] req_frame_length,
   input  logic                    req_link_up,
   output logic                    job_valid,
   input  logic                    job_ready,
   output afbf_pkg::afbf_job_type  job
);
   import afbf_pkg::*;

   localparam longint LenMax   = (64'd1 << LENGTH_WIDTH) - 64'd1;
   localparam longint MaxReset = (RESET_MAX_FRAME < LenMax) ? RESET_MAX_FRAME : LenMax;

   logic [LENGTH_WIDTH-1:0] max_ff;
   logic [31:0]             seq_ff, seq_in;
   logic [39:0]             bcd_ff, bcd_in;
   logic [3:0]              held_ff, held_in;
   logic [1:0]              phase_ff, phase_in;
   logic                    in_frame_ff, in_frame_in;
   logic                    skip_ff, skip_in;
   logic [31:0]             sent_ff, sent_in;
   logic [31:0]             drop_ff, drop_in;

   logic        accept, first, fail, nines;
   logic [31:0] seq_next;
   logic [39:0] bcd_inc, bcd_next;
   logic [3:0]  ndig, held, held_new, nib;
   logic [1:0]  phase, phase_new;
   logic [5:0]  s0, s1;
   logic [3:0][7:0] chr;
   logic [2:0]  nchr;

   assign csr_ready = 1'b1;

   always_comb begin
      accept    = req_valid && job_ready;
      req_stall = !job_ready;
      first     = !in_frame_ff;
      fail      = !req_link_up || (req_frame_length > max_ff);
      phase     = first ? 2'd0 : phase_ff;
      held      = first ? 4'd0 : held_ff;

      // decimal increment: a digit steps when every digit below it is nine
      seq_next = seq_ff + 32'd1;
      nines    = 1'b1;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         nib = bcd_ff[4*i +: 4];
         bcd_inc[4*i +: 4] = nines ? ((nib == 4'd9) ? 4'd0 : nib + 4'd1) : nib;
         nines = nines && (nib == 4'd9);
      end
      bcd_next = (seq_next == 32'd0) ? 40'd0 : bcd_inc;
      ndig = 4'd1;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_next[4*i +: 4] != 4'd0) ndig = 4'(i + 1);
      end

      s1 = 6'd0;
      unique case (phase)
         2'd0: begin
            s0 = req_data_byte[7:2]; held_new = {2'b00, req_data_byte[1:0]}; phase_new = 2'd1;
         end
         2'd1: begin
            s0 = {held[1:0], req_data_byte[7:4]}; held_new = req_data_byte[3:0];
            phase_new = 2'd2;
         end
         default: begin
            s0 = {held[3:0], req_data_byte[7:6]}; s1 = req_data_byte[5:0];
            held_new = 4'd0; phase_new = 2'd0;
         end
      endcase
      chr[0] = b64_char(s0);
      chr[1] = b64_char(s1);
      chr[2] = CHAR_PAD;
      chr[3] = CHAR_PAD;
      nchr   = (phase_new == 2'd0) ? 3'd2 : 3'd1;
      if (req_last_byte) begin
         if (phase_new == 2'd1) begin
            chr[1] = b64_char({held_new[1:0], 4'b0000}); nchr = 3'd4;
         end else if (phase_new == 2'd2) begin
            chr[1] = b64_char({held_new[3:0], 2'b00});   nchr = 3'd3;
         end
      end

      seq_in      = seq_ff;
      bcd_in      = bcd_ff;
      held_in     = held_ff;
      phase_in    = phase_ff;
      in_frame_in = in_frame_ff;
      skip_in     = skip_ff;
      sent_in     = sent_ff;
      drop_in     = drop_ff;
      job_valid   = 1'b0;

      job.drop    = 1'b0;
      job.header  = first;
      job.last    = req_last_byte;
      job.ndig    = ndig;
      job.bcd     = bcd_next;
      job.nchr    = nchr;
      job.chr     = chr;
      job.sent    = sent_ff + {31'd0, req_last_byte};
      job.dropped = drop_ff;

      if (accept) begin
         priority if (first && fail) begin
            drop_in     = drop_ff + 32'd1;
            in_frame_in = !req_last_byte;
            skip_in     = !req_last_byte;
            job.drop    = 1'b1;
            job.dropped = drop_in;
            job.sent    = sent_ff;
            job_valid   = 1'b1;
         end else if (skip_ff) begin
            // swallow the rest of a dropped frame
            if (req_last_byte) begin
               in_frame_in = 1'b0;
               skip_in     = 1'b0;
            end
         end else begin
            if (first) begin
               seq_in = seq_next;
               bcd_in = bcd_next;
            end
            sent_in     = job.sent;
            in_frame_in = !req_last_byte;
            skip_in     = 1'b0;
            held_in     = req_last_byte ? 4'd0 : held_new;
            phase_in    = req_last_byte ? 2'd0 : phase_new;
            job_valid   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff      <= LENGTH_WIDTH'(MaxReset);
         seq_ff      <= '0;
         bcd_ff      <= '0;
         held_ff     <= '0;
         phase_ff    <= '0;
         in_frame_ff <= 1'b0;
         skip_ff     <= 1'b0;
         sent_ff     <= '0;
         drop_ff     <= '0;
      end else begin
         if (csr_valid) max_ff <= csr_data;
         seq_ff      <= seq_in;
         bcd_ff      <= bcd_in;
         held_ff     <= held_in;
         phase_ff    <= phase_in;
         in_frame_ff <= in_frame_in;
         skip_ff     <= skip_in;
         sent_ff     <= sent_in;
         drop_ff     <= drop_in;
      end
   end

endmodule

@@ src/afbf_queue.sv @@
// ----------------------------------------------------------------------------
// afbf_queue : job queue between front and back
// Small register FIFO; lets the front keep accepting while the back emits.
// ----------------------------------------------------------------------------
module afbf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_valid,
   output logic                   wr_ready,
   input  afbf_pkg::afbf_job_type wr_job,
   output logic                   rd_valid,
   input  logic                   rd_take,
   output afbf_pkg::afbf_job_type rd_job
);
   import afbf_pkg::*;

   afbf_job_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                       push, pop;

   always_comb begin
      wr_ready  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
      rd_valid  = (count_ff != '0);
      rd_job    = slot_ff[rd_ptr_ff];
      push      = wr_valid && wr_ready;
      pop       = rd_take && rd_valid;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= wr_job;
   end

endmodule

@@ src/afbf_back.sv @@
// ----------------------------------------------------------------------------
// afbf_back : character sequencer
// Walks one job at a time through a drop result, or header, digits, base64
// and tail, one character per cycle unless stalled, to a registered output.
// ----------------------------------------------------------------------------
module afbf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_take,
   input  afbf_pkg::afbf_job_type job,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_line_end,
   output logic                   rsp_dropped,
   output logic [31:0]            rsp_frames_sent,
   output logic [31:0]            rsp_frames_dropped
);
   import afbf_pkg::*;

   afbf_job_type  cur_ff, cur_in;
   afbf_step_type step_ff, step_in, step_next;
   logic [4:0]    idx_ff, idx_in, idx_next;
   logic          busy_ff, busy_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    char_ff, ch;
   logic          end_ff, drop_ff, line_end, drop;
   logic [31:0]   sent_ff, dcnt_ff, sent_char;
   logic          out_free, advance, done, load, hdr_step;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = busy_ff && out_free;
      ch        = CHAR_NUL;
      line_end  = 1'b0;
      drop      = 1'b0;
      done      = 1'b0;
      hdr_step  = 1'b0;
      step_next = step_ff;
      idx_next  = idx_ff + 5'd1;

      unique case (step_ff)
         STEP_DROP: begin
            line_end = 1'b1;
            drop     = 1'b1;
            done     = 1'b1;
         end
         STEP_OPEN: begin
            hdr_step = 1'b1;
            ch = head_open_char(idx_ff);
            if (idx_ff == 5'(HEAD_OPEN_LEN - 1)) begin
               step_next = STEP_DIGIT;
               idx_next  = {1'b0, cur_ff.ndig - 4'd1};
            end
         end
         STEP_DIGIT: begin
            hdr_step = 1'b1;
            ch = CHAR_ZERO + {4'b0000, cur_ff.bcd[{idx_ff[3:0], 2'b00} +: 4]};
            idx_next = idx_ff - 5'd1;
            if (idx_ff == 5'd0) begin
               step_next = STEP_CLOSE_HDR;
               idx_next  = 5'd0;
            end
         end
         STEP_CLOSE_HDR: begin
            hdr_step = 1'b1;
            ch = head_close_char(idx_ff[2:0]);
            if (idx_ff == 5'(HEAD_CLOSE_LEN - 1)) begin
               step_next = STEP_B64;
               idx_next  = 5'd0;
            end
         end
         STEP_B64: begin
            ch = cur_ff.chr[idx_ff[1:0]];
            if (idx_ff == {2'b00, cur_ff.nchr - 3'd1}) begin
               if (cur_ff.last) begin
                  step_next = STEP_TAIL;
                  idx_next  = 5'd0;
               end else begin
                  done = 1'b1;
               end
            end
         end
         STEP_TAIL: begin
            ch = tail_char(idx_ff[1:0]);
            if (idx_ff == 5'(TAIL_LEN - 1)) begin
               line_end = 1'b1;
               done     = 1'b1;
            end
         end
         default: done = 1'b1;
      endcase

      // header characters still carry the count from before this frame closes
      sent_char = hdr_step ? (cur_ff.sent - {31'd0, cur_ff.last}) : cur_ff.sent;

      // fetch the next job in the cycle the current one finishes
      load     = (!busy_ff || (advance && done)) && job_valid;
      job_take = load;

      cur_in  = cur_ff;
      step_in = step_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         cur_in  = job;
         busy_in = 1'b1;
         idx_in  = 5'd0;
         step_in = job.drop ? STEP_DROP : (job.header ? STEP_OPEN : STEP_B64);
      end else if (advance && done) begin
         busy_in = 1'b0;
      end else if (advance) begin
         step_in = step_next;
         idx_in  = idx_next;
      end

      rsp_valid_in = out_free ? advance : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_DROP;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance) begin
         char_ff <= ch;
         end_ff  <= line_end;
         drop_ff <= drop;
         sent_ff <= sent_char;
         dcnt_ff <= cur_ff.dropped;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_char       = char_ff;
   assign rsp_line_end       = end_ff;
   assign rsp_dropped        = drop_ff;
   assign rsp_frames_sent    = sent_ff;
   assign rsp_frames_dropped = dcnt_ff;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the audio frame base64 framer
// Drives PCM frames through the request channel. A line predictor inside a
// small scoreboard turns every accepted byte into the characters the block
// should emit, and each response transaction is checked against the oldest
// one. The frame limit is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import afbf_pkg::*;

   localparam int LEN_W         = 12;
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 8;     // quiet time after the last character
   localparam int STALL_LIMIT   = 4000;  // cycles without any transaction
   localparam int MAX_REPORTS   = 10;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_CLOSE = 8'h7D;
   localparam logic [7:0] CH_NL    = 8'h0A;

   typedef struct packed {
      logic [7:0]  ch;
      logic        line_end;
      logic        dropped;
      logic [31:0] sent;
      logic [31:0] drops;
   } line_char_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the framer state, queue of predicted characters
   // -------------------------------------------------------------------------
   class line_scoreboard;
      string b64_alpha  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      string head_open  = "{\"type\":\"audio\",\"seq\":";
      string head_close = ",\"pcm\":\"";

      logic [LEN_W-1:0] limit;
      logic [31:0]      seq_num;
      logic [39:0]      seq_dec;
      logic [3:0]       held;
      logic [1:0]       group_pos;
      logic             in_frame;
      logic             skipping;
      logic [31:0]      sent_total;
      logic [31:0]      drop_total;
      line_char_type    expected_chars[$];
      int               errors;

      function new();
         limit      = LEN_W'(RESET_MAX_FRAME);
         seq_num    = '0;
         seq_dec    = '0;
         held       = '0;
         group_pos  = '0;
         in_frame   = 1'b0;
         skipping   = 1'b0;
         sent_total = '0;
         drop_total = '0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      function void push_char(logic [7:0] ch, logic le, logic dr);
         line_char_type c;
         c.ch       = ch;
         c.line_end = le;
         c.dropped  = dr;
         c.sent     = sent_total;
         c.drops    = drop_total;
         expected_chars.push_back(c);
      endfunction

      function void push_sextet(logic [5:0] v);
         push_char(b64_alpha[int'(v)], 1'b0, 1'b0);
      endfunction

      function logic [39:0] bcd_next(logic [39:0] v);
         logic [39:0] r;
         logic [4:0]  d;
         logic        carry;
         r     = '0;
         carry = 1'b1;
         for (int i = 0; i < 10; i++) begin
            d = {1'b0, v[4*i +: 4]} + carry;
            if (d >= 5'd10) begin
               d     = d - 5'd10;
               carry = 1'b1;
            end else begin
               carry = 1'b0;
            end
            r[4*i +: 4] = d[3:0];
         end
         return r;
      endfunction

      // Work out the characters that one accepted PCM byte produces
      function void note_pcm_byte(logic [7:0] b, logic last, logic [LEN_W-1:0] flen,
                                  logic link);
         logic       started;
         logic [3:0] dig;
         if (!in_frame) begin
            if (!link || flen > limit) begin
               drop_total++;
               push_char(CHAR_NUL, 1'b1, 1'b1);
               in_frame = !last;
               skipping = !last;
               return;
            end
            seq_num++;
            if (seq_num == 0) seq_dec = '0;
            else seq_dec = bcd_next(seq_dec);
            for (int i = 0; i < head_open.len(); i++) push_char(head_open[i], 1'b0, 1'b0);
            started = 1'b0;
            for (int d = 9; d >= 0; d--) begin
               dig = seq_dec[4*d +: 4];
               if (dig != 0 || started || d == 0) begin
                  started = 1'b1;
                  push_char(CHAR_ZERO + {4'd0, dig}, 1'b0, 1'b0);
               end
            end
            for (int i = 0; i < head_close.len(); i++) push_char(head_close[i], 1'b0, 1'b0);
            in_frame  = 1'b1;
            skipping  = 1'b0;
            group_pos = 2'd0;
            held      = '0;
         end else if (skipping) begin
            if (last) begin
               in_frame = 1'b0;
               skipping = 1'b0;
            end
            return;
         end

         if (last) sent_total++;

         case (group_pos)
            2'd0: begin
               push_sextet(b[7:2]);
               held      = {2'b00, b[1:0]};
               group_pos = 2'd1;
            end
            2'd1: begin
               push_sextet({held[1:0], b[7:4]});
               held      = b[3:0];
               group_pos = 2'd2;
            end
            default: begin
               push_sextet({held[3:0], b[7:6]});
               push_sextet(b[5:0]);
               held      = '0;
               group_pos = 2'd0;
            end
         endcase

         if (last) begin
            if (group_pos == 2'd1) begin
               push_sextet({held[1:0], 4'b0000});
               push_char(CHAR_PAD, 1'b0, 1'b0);
               push_char(CHAR_PAD, 1'b0, 1'b0);
            end else if (group_pos == 2'd2) begin
               push_sextet({held[3:0], 2'b00});
               push_char(CHAR_PAD, 1'b0, 1'b0);
            end
            push_char(CH_QUOTE, 1'b0, 1'b0);
            push_char(CH_CLOSE, 1'b0, 1'b0);
            push_char(CH_NL, 1'b1, 1'b0);
            held      = '0;
            group_pos = 2'd0;
            in_frame  = 1'b0;
            skipping  = 1'b0;
         end
      endfunction

      function void check_char(line_char_type got);
         line_char_type want;
         if (expected_chars.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected character %h end %b drop %b sent %0d dropped %0d",
                        $realtime, got.ch, got.line_end, got.dropped, got.sent, got.drops);
            return;
         end
         want = expected_chars.pop_front();
         if (got.ch !== want.ch || got.line_end !== want.line_end ||
             got.dropped !== want.dropped || got.sent !== want.sent ||
             got.drops !== want.drops) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: mismatch, expected char %h end %b drop %b sent %0d dropped %0d",
                        $realtime, want.ch, want.line_end, want.dropped, want.sent, want.drops);
               $display("%0t:           actual char %h end %b drop %b sent %0d dropped %0d",
                        $realtime, got.ch, got.line_end, got.dropped, got.sent, got.drops);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [7:0]       req_data_byte;
   logic             req_last_byte;
   logic [LEN_W-1:0] req_frame_length;
   logic             req_link_up;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [7:0]       rsp_out_char;
   logic             rsp_line_end;
   logic             rsp_dropped;
   logic [31:0]      rsp_frames_sent;
   logic [31:0]      rsp_frames_dropped;
   logic             csr_valid;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_data;

   audio_frame_base64_framer #(.LENGTH_WIDTH(LEN_W)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_frame_length   (req_frame_length),
      .req_link_up        (req_link_up),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_line_end       (rsp_line_end),
      .rsp_dropped        (rsp_dropped),
      .rsp_frames_sent    (rsp_frames_sent),
      .rsp_frames_dropped (rsp_frames_dropped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   line_scoreboard sb;
   bit             quiet;      // last part of the run: no idling on either side
   bit             hold_req;   // ask the receiver for one long hold-off
   int             idle_cycles;

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // -------------------------------------------------------------------------
   // Receiver: random stall bursts, plus the long hold-off on request.
   // Stall changes only at the falling edge.
   // -------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            // hold off long enough for the job queue to fill and stall the input
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check every response transaction at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_char('{rsp_out_char, rsp_line_end, rsp_dropped,
                         rsp_frames_sent, rsp_frames_dropped});
   end

   // Watchdog: end the run if no transaction of any kind moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks. Each is entered just after a falling edge and returns just
   // after one, so every input gets at most one update per edge.
   // -------------------------------------------------------------------------

   // Offer one byte, with an occasional idle burst first; hold it until taken
   task automatic offer_byte(input logic [7:0] b, input logic last,
                             input logic [LEN_W-1:0] flen, input logic link);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_last_byte    <= last;
      req_frame_length <= flen;
      req_link_up      <= link;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pcm_byte(b, last, flen, link);
      @(negedge clock);
   endtask

   // Drop valid and wait for every predicted character, then let the back end settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_frame_limit(input logic [LEN_W-1:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.limit = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Length and link matter on the first byte only; randomise them elsewhere
   task automatic send_frame(input int unsigned nbytes, input logic [LEN_W-1:0] flen,
                             input logic link);
      for (int unsigned i = 0; i < nbytes; i++) begin
         if (i == 0) offer_byte(8'($urandom), nbytes == 1, flen, link);
         else offer_byte(8'($urandom), i == nbytes - 1, LEN_W'($urandom), 1'($urandom));
      end
   endtask

   // Mostly admitted frames of random content; some with the link down or
   // over the limit, which the block swallows after one drop result
   task automatic send_random_frames(input int unsigned quota);
      int unsigned      counted;
      int unsigned      nbytes;
      int unsigned      pick;
      logic [LEN_W-1:0] flen;
      logic             link;
      counted = 0;
      while (counted < quota) begin
         nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
         pick   = $urandom_range(0, 19);
         if (pick < 14) flen = LEN_W'($urandom_range(0, sb.limit));
         else if (pick < 17 && sb.limit < {LEN_W{1'b1}})
            flen = LEN_W'($urandom_range(sb.limit + 1, 4095));
         else flen = LEN_W'($urandom);
         link = ($urandom_range(0, 7) != 0);
         // every offered byte is an input transaction, swallowed or not
         counted += nbytes;
         send_frame(nbytes, flen, link);
         if (!quiet && $urandom_range(0, 24) == 0) wait_drained();
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb               = new();
      quiet            = 1'b0;
      hold_req         = 1'b0;
      idle_cycles      = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_last_byte    = 1'b0;
      req_frame_length = '0;
      req_link_up      = 1'b0;
      csr_valid        = 1'b0;
      csr_data         = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames at the reset limit
      // single byte: header, two pad characters and the closing in one go
      offer_byte(8'h00, 1'b1, 12'd1, 1'b1);
      // two bytes: one pad character
      offer_byte(8'hFF, 1'b0, 12'd2, 1'b1);
      offer_byte(8'h80, 1'b1, 12'd2, 1'b1);
      // three bytes: full group, no padding
      offer_byte(8'hFF, 1'b0, 12'd3, 1'b1);
      offer_byte(8'h00, 1'b0, 12'd0, 1'b0);
      offer_byte(8'hAA, 1'b1, 12'hFFF, 1'b0);
      // declared length zero is admitted; actual length differs
      offer_byte(8'h55, 1'b0, 12'd0, 1'b1);
      offer_byte(8'h01, 1'b0, 12'd7, 1'b0);
      offer_byte(8'hFE, 1'b0, 12'd7, 1'b1);
      offer_byte(8'h7F, 1'b1, 12'd7, 1'b1);
      // link down on a single-byte frame
      offer_byte(8'h12, 1'b1, 12'd1, 1'b0);
      // link down on a longer frame: one drop, then swallow to the last byte
      offer_byte(8'h34, 1'b0, 12'd3, 1'b0);
      offer_byte(8'h56, 1'b0, 12'd3, 1'b1);
      offer_byte(8'h78, 1'b1, 12'd3, 1'b1);
      // declared length at the top of the range: over the limit
      offer_byte(8'h9A, 1'b0, 12'hFFF, 1'b1);
      offer_byte(8'hBC, 1'b1, 12'd1, 1'b1);
      // exactly at the limit, then one over it
      offer_byte(8'hDE, 1'b0, 12'd1161, 1'b1);
      offer_byte(8'hF0, 1'b1, 12'd1161, 1'b1);
      offer_byte(8'h0F, 1'b1, 12'd1162, 1'b1);

      // Smallest limit: frames that declare a length above one drop
      write_frame_limit(12'd1);
      send_random_frames(40);

      // Largest limit, with the long receiver hold-off while frames keep coming
      write_frame_limit(12'hFFF);
      hold_req = 1'b1;
      send_random_frames(50);

      // An even limit from 2 to 4094
      write_frame_limit(LEN_W'($urandom_range(1, 2047) * 2));
      send_random_frames(50);

      // Back to the reset value; no idling on either side from here on
      write_frame_limit(LEN_W'(RESET_MAX_FRAME));
      quiet = 1'b1;
      send_random_frames(50);

      wait_drained();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
